// ===== rtl/core/boolean_transitive_closure_unit_assert.svh =====
// Assertion macros shared by the checker of the closure unit.
// Needs nothing else; take it in with an include.
`ifndef BOOLEAN_TRANSITIVE_CLOSURE_UNIT_ASSERT_SVH
`define BOOLEAN_TRANSITIVE_CLOSURE_UNIT_ASSERT_SVH

// Same-cycle implication under clock and reset.
`define BTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("closure unit check failed");

// Next-cycle implication under clock and reset.
`define BTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("closure unit check failed");

`endif

// ===== rtl/core/btc_pkg.sv =====
// Types and constants of the transitive closure unit.
// No dependencies; every module of the block imports it.
package btc_pkg;

   localparam int ROW_W     = 32;
   localparam int ROW_IDX_W = 5;
   localparam int NC_W      = 6;

   localparam logic [NC_W-1:0] NODE_COUNT_RESET = 6'd32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic [ROW_IDX_W-1:0] idx;
      logic                 last;
      logic [ROW_W-1:0]     row;
   } q_entry_type;

   typedef enum logic [2:0] {
      BK_LOAD,
      BK_PIV_RD,
      BK_PIV_LD,
      BK_SCAN,
      BK_DRAIN,
      BK_EM_RD,
      BK_EM_WR
   } back_state_type;

endpackage

// ===== rtl/core/boolean_transitive_closure_unit.sv =====
// Top level of the Boolean transitive closure (Warshall) unit.
// Depends on btc_pkg, btc_front, btc_queue and btc_back.
//
// Send the adjacency matrix of an N-node graph as N row transactions on the
// req_ channel, row 0 first; N is csr_node_count clamped to 1..min(MAX_NODES,32),
// and row bits at or above N are dropped. Once the last row is in, the unit
// runs Warshall's closure in place and returns N rsp_ transactions, rows 0 to
// N-1 in order, rsp_last_row high on the last one. The diagonal is not forced.
// Sequence per matrix: rows land in the row memory behind a two-entry
// queue while the back end is loading; the closure then sweeps the
// row memory once per pivot (pivot read, pivot capture, N row reads with
// each update written in the cycle after its read, one drain step); the emit
// then reads each row and registers it for the rsp_ channel. The memory sweep
// dominates the time per matrix. The queue takes up to two rows of the next
// matrix while the sweep runs; a result held by the receiver stalls the emit,
// and with it the input once the queue is full.
// Writing node_count discards a partly loaded matrix; write it only when the
// unit is idle. The row memory needs no clearing pass after reset.
module boolean_transitive_closure_unit
   import btc_pkg::*;
#(
   parameter int MAX_NODES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ROW_W-1:0]     req_row_bits,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ROW_IDX_W-1:0] rsp_row_index,
   output logic [ROW_W-1:0]     rsp_reach_bits,
   output logic                 rsp_last_row,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [NC_W-1:0]      csr_node_count
);

   localparam int RowLimit = (MAX_NODES < 32) ? MAX_NODES : 32;
   localparam int CntW     = $clog2(RowLimit + 1);

   logic [NC_W-1:0] node_count_ff, node_count_in;
   logic [CntW-1:0] n_cnt;
   logic            cfg_we;
   logic            q_push, q_ready, q_valid, q_pop;
   q_entry_type     q_in_entry, q_out_entry;

   // Always take configuration writes.
   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid && csr_ready;

   always_comb begin
      node_count_in = node_count_ff;
      if (cfg_we) begin
         node_count_in = csr_node_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   // Clamp the node count to the range the row memory holds.
   always_comb begin
      if (node_count_ff == '0) begin
         n_cnt = CntW'(1);
      end else if (node_count_ff > NC_W'(RowLimit)) begin
         n_cnt = CntW'(RowLimit);
      end else begin
         n_cnt = CntW'(node_count_ff);
      end
   end

   btc_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .n_cnt        (n_cnt),
      .cfg_we       (cfg_we),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_row_bits (req_row_bits),
      .q_ready      (q_ready),
      .q_push       (q_push),
      .q_entry      (q_in_entry)
   );

   btc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_out_entry)
   );

   btc_back #(
      .MAX_NODES (MAX_NODES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .n_cnt          (n_cnt),
      .q_valid        (q_valid),
      .q_entry        (q_out_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_index  (rsp_row_index),
      .rsp_reach_bits (rsp_reach_bits),
      .rsp_last_row   (rsp_last_row)
   );

endmodule

// ===== rtl/core/btc_queue.sv =====
// Two-entry queue between the row front end and the closure back end.
// Depends on btc_pkg for the entry type and depth constants.
module btc_queue
   import btc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_data,
   output logic        push_ready,
   input  logic        pop,
   output logic        pop_valid,
   output q_entry_type pop_data
);

   q_entry_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && push_ready) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop && pop_valid) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if ((push && push_ready) && !(pop && pop_valid)) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!(push && push_ready) && (pop && pop_valid)) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_ready) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/btc_front.sv =====
// Front end: takes adjacency rows, masks them and tags index and end of matrix.
// Depends on btc_pkg; feeds btc_queue.
module btc_front
   import btc_pkg::*;
#(
   parameter int MAX_NODES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [$clog2(((MAX_NODES < 32) ? MAX_NODES : 32) + 1)-1:0] n_cnt,
   input  logic                  cfg_we,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ROW_W-1:0]      req_row_bits,
   input  logic                  q_ready,
   output logic                  q_push,
   output q_entry_type           q_entry
);

   localparam int RowLimit = (MAX_NODES < 32) ? MAX_NODES : 32;
   localparam int IdxW     = $clog2(RowLimit);
   localparam int CntW     = $clog2(RowLimit + 1);

   logic [IdxW-1:0]  cnt_ff, cnt_in;
   logic [ROW_W-1:0] mask;
   logic             row_last;

   always_comb begin
      for (int j = 0; j < ROW_W; j++) begin
         mask[j] = (j < int'(n_cnt));
      end
   end

   assign row_last  = ((CntW'(cnt_ff) + CntW'(1)) == n_cnt);
   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;

   assign q_entry.idx  = ROW_IDX_W'(cnt_ff);
   assign q_entry.last = row_last;
   assign q_entry.row  = req_row_bits & mask;

   always_comb begin
      cnt_in = cnt_ff;
      if (cfg_we) begin
         cnt_in = '0;
      end else if (q_push) begin
         cnt_in = row_last ? '0 : cnt_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/btc_back.sv =====
// Back end: row memory, Warshall sweep sequencer and result register.
// Depends on btc_pkg; drains btc_queue.
module btc_back
   import btc_pkg::*;
#(
   parameter int MAX_NODES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [$clog2(((MAX_NODES < 32) ? MAX_NODES : 32) + 1)-1:0] n_cnt,
   input  logic                  q_valid,
   input  q_entry_type           q_entry,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ROW_IDX_W-1:0]  rsp_row_index,
   output logic [ROW_W-1:0]      rsp_reach_bits,
   output logic                  rsp_last_row
);

   localparam int RowLimit = (MAX_NODES < 32) ? MAX_NODES : 32;
   localparam int IdxW     = $clog2(RowLimit);
   localparam int CntW     = $clog2(RowLimit + 1);

   logic [ROW_W-1:0] row_mem [RowLimit];

   back_state_type   state_ff, state_in;
   logic [IdxW-1:0]  k_ff, k_in;
   logic [IdxW-1:0]  i_ff, i_in;
   logic             upd_ff, upd_in;
   logic [IdxW-1:0]  upd_idx_ff, upd_idx_in;
   logic [ROW_W-1:0] pivot_ff, pivot_in;
   logic [ROW_W-1:0] rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [ROW_W-1:0] rsp_bits_ff, rsp_bits_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [IdxW-1:0]  rd_addr;
   logic             mem_we;
   logic [IdxW-1:0]  mem_wa;
   logic [ROW_W-1:0] mem_wd;
   logic [CntW-1:0]  n_m1;
   logic             i_last, k_last, out_free;

   assign n_m1     = n_cnt - CntW'(1);
   assign i_last   = (CntW'(i_ff) == n_m1);
   assign k_last   = (CntW'(k_ff) == n_m1);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Memory write port: loading in idle, row update during the sweep.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = upd_idx_ff;
      mem_wd = rd_data_ff | pivot_ff;
      if (state_ff == BK_LOAD && q_valid) begin
         mem_we = 1'b1;
         mem_wa = q_entry.idx[IdxW-1:0];
         mem_wd = q_entry.row;
      end else if (upd_ff && rd_data_ff[k_ff]) begin
         mem_we = 1'b1;
      end
   end

   assign rd_addr = (state_ff == BK_PIV_RD) ? k_ff : i_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      upd_in       = 1'b0;
      upd_idx_in   = i_ff;
      pivot_in     = pivot_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         BK_LOAD: begin
            q_pop = q_valid;
            if (q_valid && q_entry.last) begin
               k_in     = '0;
               i_in     = '0;
               state_in = BK_PIV_RD;
            end
         end
         BK_PIV_RD: begin
            state_in = BK_PIV_LD;
         end
         BK_PIV_LD: begin
            pivot_in = rd_data_ff;
            state_in = BK_SCAN;
         end
         BK_SCAN: begin
            upd_in = 1'b1;
            if (i_last) begin
               i_in     = '0;
               state_in = BK_DRAIN;
            end else begin
               i_in = i_ff + IdxW'(1);
            end
         end
         BK_DRAIN: begin
            if (k_last) begin
               state_in = BK_EM_RD;
            end else begin
               k_in     = k_ff + IdxW'(1);
               state_in = BK_PIV_RD;
            end
         end
         BK_EM_RD: begin
            state_in = BK_EM_WR;
         end
         BK_EM_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = ROW_IDX_W'(i_ff);
               rsp_bits_in  = rd_data_ff;
               rsp_last_in  = i_last;
               if (i_last) begin
                  i_in     = '0;
                  state_in = BK_LOAD;
               end else begin
                  i_in     = i_ff + IdxW'(1);
                  state_in = BK_EM_RD;
               end
            end
         end
         default: begin
            state_in = BK_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_LOAD;
         k_ff         <= '0;
         i_ff         <= '0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      upd_idx_ff  <= upd_idx_in;
      pivot_ff    <= pivot_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= row_mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_index  = rsp_idx_ff;
   assign rsp_reach_bits = rsp_bits_ff;
   assign rsp_last_row   = rsp_last_ff;

endmodule

// ===== rtl/core/btc_checker.sv =====
// Port-level checker of the closure unit, bound to the top level.
// Depends on btc_pkg and boolean_transitive_closure_unit_assert.svh.
`include "boolean_transitive_closure_unit_assert.svh"

module btc_checker
   import btc_pkg::*;
#(
   parameter int MAX_NODES = 32
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [ROW_W-1:0]     req_row_bits,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ROW_IDX_W-1:0] rsp_row_index,
   input logic [ROW_W-1:0]     rsp_reach_bits,
   input logic                 rsp_last_row,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [NC_W-1:0]      csr_node_count
);

   localparam int RowLimit = (MAX_NODES < 32) ? MAX_NODES : 32;

   logic [NC_W-1:0]  nc_ff, nc_in;
   logic [NC_W-1:0]  n_eff;
   logic [ROW_W-1:0] mask;
   logic             in_seen;

   // Track the node count as written through the port.
   always_comb begin
      nc_in = nc_ff;
      if (csr_valid && csr_ready) begin
         nc_in = csr_node_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff <= NODE_COUNT_RESET;
      end else begin
         nc_ff <= nc_in;
      end
   end

   always_comb begin
      if (nc_ff == '0) begin
         n_eff = NC_W'(1);
      end else if (nc_ff > NC_W'(RowLimit)) begin
         n_eff = NC_W'(RowLimit);
      end else begin
         n_eff = nc_ff;
      end
      for (int j = 0; j < ROW_W; j++) begin
         mask[j] = (j < int'(n_eff));
      end
   end

   assign in_seen = req_valid && req_ready && (req_row_bits != req_row_bits);

   `BTC_ASSERT_NOW(a_index_in_range, clock, reset, rsp_valid && !in_seen,
      NC_W'(rsp_row_index) < n_eff)

   `BTC_ASSERT_NOW(a_last_on_final_row, clock, reset, rsp_valid,
      rsp_last_row == (NC_W'(rsp_row_index) == n_eff - NC_W'(1)))

   `BTC_ASSERT_NOW(a_high_bits_clear, clock, reset, rsp_valid,
      (rsp_reach_bits & ~mask) == '0)

   `BTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_row_index) && $stable(rsp_reach_bits) && $stable(rsp_last_row))

endmodule

bind boolean_transitive_closure_unit btc_checker #(
   .MAX_NODES (MAX_NODES)
) u_btc_checker (.*);
